[rtl/mhpq_pkg.sv]
// ----------------------------------------------------------------------------
// mhpq_pkg - shared definitions for the max-heap priority queue
// Sizes, action and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int DEPTH    = 1024;
  localparam int KEY_W    = 32;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int ACT_W    = 2;
  localparam int STAT_W   = 3;
  localparam int IN_DW    = 48;   // key + index, padded to whole bytes
  localparam int OUT_DW   = 48;   // value + status + count, padded

  localparam logic [ACT_W-1:0] ACT_INSERT   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_EXTRACT  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_INCREASE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NONE     = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STAT_W-1:0] ST_SMALLER = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_IDX = 3'd4;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_UP_RD  = 8'b0000_0010,
    S_UP_CMP = 8'b0000_0100,
    S_DN_RD  = 8'b0000_1000,
    S_DN_CMP = 8'b0001_0000,
    S_EX_CMP = 8'b0010_0000,
    S_IN_CMP = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

endpackage

[rtl/max_heap_priority_queue.sv]
// Sequence: an error or the unused action goes straight to the result; insert
//   climbs level by level; increase-key compares with the old key, then climbs;
//   extract reads the root and last entry, then sinks that entry level by level.
// Throughput: one beat in flight; in_tready high only while idle.
// Reset: synchronous, active low; clears count and handshake state, not the RAM.
// ----------------------------------------------------------------------------
// max_heap_priority_queue - binary max-heap of signed keys
// Insert, extract-max and increase-key on a RAM-held heap, stepping one
// tree level at a time through a read state and a compare state.
// ----------------------------------------------------------------------------
module max_heap_priority_queue import mhpq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // [31:0] key, [41:32] index, rest zero
  input  logic [ACT_W-1:0]  in_tuser,   // [1:0] action
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata   // [31:0] value, [34:32] status,
                                        // [45:35] count, rest zero
);

  // --------------------------------------------------------------------------
  // Heap RAM: one write port, two registered read ports
  // --------------------------------------------------------------------------
  logic signed [KEY_W-1:0] mem [DEPTH];
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic signed [KEY_W-1:0] wr_data;
  logic [ADDR_W-1:0]       rd_addr_a, rd_addr_b;
  logic signed [KEY_W-1:0] rd_a_r, rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  // --------------------------------------------------------------------------
  // Sequencer registers
  // --------------------------------------------------------------------------
  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [ADDR_W-1:0]       pos_r, pos_nxt;      // hole being moved
  logic signed [KEY_W-1:0] key_r, key_nxt;      // key travelling with the hole
  logic signed [KEY_W-1:0] val_r, val_nxt;      // result value
  logic [STAT_W-1:0]       stat_r, stat_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_DW-1:0]       out_data_r, out_data_nxt;

  // beat fields
  logic signed [KEY_W-1:0] in_key;
  logic [ADDR_W-1:0]       in_index;
  logic                    in_fire;

  assign in_key   = in_tdata[KEY_W-1:0];
  assign in_index = in_tdata[KEY_W +: ADDR_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire  = in_tvalid && in_tready;

  // tree neighbours of the hole
  logic [ADDR_W-1:0]  parent;
  logic [CNT_W:0]     left_c, right_c;
  logic               left_ok, right_ok;
  logic [CNT_W-1:0]   count_dec;

  assign parent    = (pos_r - ADDR_W'(1)) >> 1;
  assign left_c    = {1'b0, pos_r, 1'b1};                       // 2*pos + 1
  assign right_c   = {1'b0, pos_r, 1'b1} + (CNT_W + 1)'(1);     // 2*pos + 2
  assign left_ok   = left_c  < {1'b0, count_r};
  assign right_ok  = right_c < {1'b0, count_r};
  assign count_dec = count_r - CNT_W'(1);

  // read address selection
  always_comb begin
    rd_addr_a = '0;
    rd_addr_b = count_dec[ADDR_W-1:0];   // last entry, used by extract
    unique case (state_r)
      S_IDLE: begin
        if (in_tuser == ACT_INCREASE) begin
          rd_addr_a = in_index;
        end
      end
      S_UP_RD: rd_addr_a = parent;
      S_DN_RD: begin
        rd_addr_a = left_c[ADDR_W-1:0];
        rd_addr_b = right_c[ADDR_W-1:0];   // masked by right_ok if past the end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Next-state logic: one compare per level, hole moves, key written last
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = key_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          val_nxt  = '0;
          stat_nxt = ST_OK;
          key_nxt  = in_key;
          state_nxt = S_DONE;
          unique case (in_tuser)
            ACT_INSERT: begin
              if (count_r == CNT_W'(DEPTH)) begin
                stat_nxt = ST_FULL;
              end else begin
                pos_nxt   = count_r[ADDR_W-1:0];
                count_nxt = count_r + CNT_W'(1);
                state_nxt = S_UP_RD;
              end
            end
            ACT_EXTRACT: begin
              if (count_r == '0) begin
                stat_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_EX_CMP;
              end
            end
            ACT_INCREASE: begin
              if ({1'b0, in_index} >= count_r) begin
                stat_nxt = ST_BAD_IDX;
              end else begin
                pos_nxt   = in_index;
                state_nxt = S_IN_CMP;
              end
            end
            ACT_NONE: ;
            default: ;
          endcase
        end
      end

      // sift-up: settle at the root, else fetch the parent
      S_UP_RD: begin
        if (pos_r == '0) begin
          wr_en     = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        wr_en = 1'b1;
        if (rd_a_r < key_r) begin
          wr_data   = rd_a_r;      // parent drops into the hole
          pos_nxt   = parent;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // sift-down: a leaf ends it, else fetch both children
      S_DN_RD: begin
        if (!left_ok) begin
          wr_en     = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end

      S_DN_CMP: begin
        wr_en = 1'b1;
        // ties keep the hole, then prefer the left child
        priority if (right_ok && rd_b_r > rd_a_r && rd_b_r > key_r) begin
          wr_data   = rd_b_r;
          pos_nxt   = right_c[ADDR_W-1:0];
          state_nxt = S_DN_RD;
        end else if (rd_a_r > key_r) begin
          wr_data   = rd_a_r;
          pos_nxt   = left_c[ADDR_W-1:0];
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // root and last entry are in; last entry sinks from the root unless it was the only one
      S_EX_CMP: begin
        val_nxt   = rd_a_r;
        key_nxt   = rd_b_r;
        count_nxt = count_dec;
        pos_nxt   = '0;
        state_nxt = (count_dec == '0) ? S_DONE : S_DN_RD;
      end

      S_IN_CMP: begin
        if (key_r < rd_a_r) begin
          stat_nxt  = ST_SMALLER;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_UP_RD;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt[KEY_W-1:0]             = val_r;
          out_data_nxt[KEY_W +: STAT_W]       = stat_r;
          out_data_nxt[KEY_W + STAT_W +: CNT_W] = count_r;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    stat_r     <= stat_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
